### rtl/core/hos_pkg.sv
// Package for the homography outlier scorer: widths, reset values and shared types.
// Used by the top level, hos_front and hos_back, and by the dv checker and testbench; depends on nothing.
`default_nettype none
package hos_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;
  localparam int TOTAL_W = 16;
  localparam int RATIO_W = 17;
  localparam int THR_W = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAIR_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR = 3'd5;

  localparam logic [63:0] PAIR_A_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] PAIR_B_RST = 64'h0;
  localparam logic [63:0] PAIR_C_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] PAIR_D_RST = 64'h0;
  localparam logic [31:0] LAST_RST = 32'h4000_0000;
  localparam logic [THR_W-1:0] THR_RST = 20'd9;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

### rtl/core/homography_outlier_scorer.sv
// Top level of the homography outlier scorer: configuration registers and part wiring.
// Depends on hos_pkg, hos_front, hos_queue and hos_back.
//
// One result beat per input beat. An item passes through the projection front end and the
// queue, and its result beat is offered once the back end is free; the last pair of a set
// first goes through the bit-serial ratio divider. At most two items sit in the front end
// and the queue together, so a new input beat can be accepted while an earlier item is
// still in flight, and the input stalls while two are.
`default_nettype none
module homography_outlier_scorer #(
  parameter int COORD_BITS = hos_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = hos_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_ref_x,
  input  wire logic [COORD_BITS-1:0] in_ref_y,
  input  wire logic [COORD_BITS-1:0] in_src_x,
  input  wire logic [COORD_BITS-1:0] in_src_y,
  input  wire logic                  in_last_pair,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_is_outlier,
  output logic [hos_pkg::TOTAL_W-1:0] out_outlier_total,
  output logic [hos_pkg::TOTAL_W-1:0] out_pair_total,
  output logic [hos_pkg::RATIO_W-1:0] out_outlier_ratio,
  output logic                       out_done_res,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [hos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]           cfg_data
);
  logic [63:0] pa_r, pb_r, pc_r, pd_r;
  logic [31:0] pl_r;
  logic [hos_pkg::THR_W-1:0] thr_r;
  logic go, fbusy, fvalid, foutl, flast, pop, qne;
  logic [1:0] qdata, qfill;
  logic [2:0] inflight;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= hos_pkg::PAIR_A_RST;
      pb_r <= hos_pkg::PAIR_B_RST;
      pc_r <= hos_pkg::PAIR_C_RST;
      pd_r <= hos_pkg::PAIR_D_RST;
      pl_r <= hos_pkg::LAST_RST;
      thr_r <= hos_pkg::THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        hos_pkg::REG_PAIR_A: pa_r <= cfg_data;
        hos_pkg::REG_PAIR_B: pb_r <= cfg_data;
        hos_pkg::REG_PAIR_C: pc_r <= cfg_data;
        hos_pkg::REG_PAIR_D: pd_r <= cfg_data;
        hos_pkg::REG_LAST:   pl_r <= cfg_data[31:0];
        hos_pkg::REG_THR:    thr_r <= cfg_data[hos_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Items in the front stages plus the queue never exceed the queue depth.
  logic [2:0] front_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) front_cnt_r <= '0;
    else front_cnt_r <= front_cnt_r + 3'(go) - 3'(fvalid);
  end
  assign inflight = front_cnt_r + 3'(qfill);
  assign in_stall = inflight >= 3'd2;
  assign go = in_valid && !in_stall;

  hos_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_go(go),
    .rx(in_ref_x), .ry(in_ref_y), .sx(in_src_x), .sy(in_src_y), .last_in(in_last_pair),
    .pa(pa_r), .pb(pb_r), .pc(pc_r), .pd(pd_r), .pl(pl_r), .thr(thr_r),
    .busy(fbusy), .res_valid(fvalid), .res_outlier(foutl), .res_last(flast)
  );

  hos_queue u_queue (
    .clk, .rst_n, .wr_en(fvalid), .wr_data({flast, foutl}),
    .rd_en(pop), .rd_data(qdata), .not_empty(qne), .fill(qfill)
  );

  hos_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid(qne), .q_data(qdata), .q_pop(pop),
    .out_valid, .out_stall, .out_is_outlier, .out_outlier_total, .out_pair_total,
    .out_outlier_ratio, .out_done_res
  );

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (front_cnt_r != '0) == fbusy) else $error("front count out of step");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= 3'd2) else $error("queue overrun possible");
  a_qfill: assert property (@(posedge clk) disable iff (!rst_n)
    qfill <= 2'd2) else $error("queue overfilled");
endmodule
`default_nettype wire

### rtl/core/hos_front.sv
// Front part: projects each pair through the homography and classifies it.
// Four registered stages; depends on hos_pkg.
`default_nettype none
module hos_front #(
  parameter int COORD_BITS = hos_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_go,
  input  wire logic [COORD_BITS-1:0] rx,
  input  wire logic [COORD_BITS-1:0] ry,
  input  wire logic [COORD_BITS-1:0] sx,
  input  wire logic [COORD_BITS-1:0] sy,
  input  wire logic                  last_in,
  input  wire logic [63:0]           pa,
  input  wire logic [63:0]           pb,
  input  wire logic [63:0]           pc,
  input  wire logic [63:0]           pd,
  input  wire logic [31:0]           pl,
  input  wire logic [hos_pkg::THR_W-1:0] thr,
  output logic                       busy,
  output logic                       res_valid,
  output logic                       res_outlier,
  output logic                       res_last
);
  localparam int THR_W = hos_pkg::THR_W;
  localparam int PW = 32 + COORD_BITS + 2;
  localparam int DW = PW + COORD_BITS + 2;
  localparam int SW = 2 * DW + 1;
  localparam int ZW = PW - 14;
  localparam int HW = (DW + 1) / 2;
  localparam int UW = DW - HW;
  localparam int RW = 2 * ZW + THR_W;

  logic [3:0] v_r;
  logic [COORD_BITS-1:0] rx_r, ry_r;
  logic last1_r, last2_r, last3_r, last4_r;
  logic signed [PW-1:0] x_r, y_r, z_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [2*ZW-1:0] zz_r;
  logic zz2_r, zz3_r;
  logic [2*UW-1:0] xhh_r, yhh_r;
  logic [DW-1:0] xhl_r, yhl_r;
  logic [2*HW-1:0] xll_r, yll_r;
  logic [ZW+THR_W-1:0] th_r, tl_r;
  logic [SW-1:0] lhs;
  logic [RW-1:0] rhs;
  logic signed [PW-1:0] zraw;
  logic signed [ZW-1:0] zs;
  logic [ZW-1:0] zm;
  logic [DW-1:0] adx, ady;

  function automatic logic signed [PW-1:0] mulc(input logic [31:0] h,
                                               input logic [COORD_BITS-1:0] c);
    logic signed [PW-1:0] hv, cv;
    hv = PW'($signed(h));
    cv = PW'($signed({1'b0, c}));
    return hv * cv;
  endfunction

  assign zraw = mulc(pd[63:32], sx) + mulc(pd[31:0], sy) + PW'($signed(pl));
  assign zs = $signed(z_r[ZW-1:0]);
  assign zm = zs[ZW-1] ? $unsigned(-zs) : $unsigned(zs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_go};
    end
    if (in_go) begin
      x_r <= mulc(pa[63:32], sx) + mulc(pa[31:0], sy) + PW'($signed(pb[63:32]));
      y_r <= mulc(pb[31:0], sx) + mulc(pc[63:32], sy) + PW'($signed(pc[31:0]));
      z_r <= zraw >>> 14;
      rx_r <= rx;
      ry_r <= ry;
      last1_r <= last_in;
    end
    if (v_r[0]) begin
      dx_r <= DW'(x_r) - DW'(z_r) * DW'($signed({1'b0, rx_r}));
      dy_r <= DW'(y_r) - DW'(z_r) * DW'($signed({1'b0, ry_r}));
      zz_r <= (2*ZW)'(zm) * (2*ZW)'(zm);
      zz2_r <= (z_r == '0);
      last2_r <= last1_r;
    end
    if (v_r[1]) begin
      xhh_r <= (2*UW)'(adx[DW-1:HW]) * (2*UW)'(adx[DW-1:HW]);
      xhl_r <= DW'(adx[DW-1:HW]) * DW'(adx[HW-1:0]);
      xll_r <= (2*HW)'(adx[HW-1:0]) * (2*HW)'(adx[HW-1:0]);
      yhh_r <= (2*UW)'(ady[DW-1:HW]) * (2*UW)'(ady[DW-1:HW]);
      yhl_r <= DW'(ady[DW-1:HW]) * DW'(ady[HW-1:0]);
      yll_r <= (2*HW)'(ady[HW-1:0]) * (2*HW)'(ady[HW-1:0]);
      th_r <= (ZW+THR_W)'(zz_r[2*ZW-1:ZW]) * (ZW+THR_W)'(thr);
      tl_r <= (ZW+THR_W)'(zz_r[ZW-1:0]) * (ZW+THR_W)'(thr);
      zz3_r <= zz2_r;
      last3_r <= last2_r;
    end
    if (v_r[2]) begin
      res_outlier <= zz3_r || (lhs > SW'(rhs));
      last4_r <= last3_r;
    end
  end

  assign adx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ady = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign lhs = (SW'(xhh_r) << (2 * HW)) + (SW'(xhl_r) << (HW + 1)) + SW'(xll_r)
             + (SW'(yhh_r) << (2 * HW)) + (SW'(yhl_r) << (HW + 1)) + SW'(yll_r);
  assign rhs = (RW'(th_r) << ZW) + RW'(tl_r);

  assign busy = |v_r;
  assign res_valid = v_r[3];
  assign res_last = last4_r;
endmodule
`default_nettype wire

### rtl/core/hos_queue.sv
// Short queue between the front and back parts.
// Two entries of outlier and last flags; depends on nothing.
`default_nettype none
module hos_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [1:0] wr_data,
  input  wire logic       rd_en,
  output logic [1:0]      rd_data,
  output logic            not_empty,
  output logic [1:0]      fill
);
  logic [1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
  assign rd_data = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign fill = cnt_r;
endmodule
`default_nettype wire

### rtl/core/hos_back.sv
// Back part: counts outliers and pairs, forms the final ratio, holds the result beat.
// Uses hos_pkg for the state type and widths.
`default_nettype none
module hos_back #(
  parameter int COUNT_BITS = hos_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire logic [1:0] q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_is_outlier,
  output logic [hos_pkg::TOTAL_W-1:0] out_outlier_total,
  output logic [hos_pkg::TOTAL_W-1:0] out_pair_total,
  output logic [hos_pkg::RATIO_W-1:0] out_outlier_ratio,
  output logic            out_done_res
);
  localparam int NW = COUNT_BITS + 16;
  localparam int IW = $clog2(NW + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  hos_pkg::bk_state_t st_r, st_nxt;
  logic [COUNT_BITS-1:0] oc_r, pc_r, oc_v, pc_v;
  logic [NW-1:0] num_r;
  logic [COUNT_BITS:0] rem_r, rem_try;
  logic [COUNT_BITS-1:0] den_r;
  logic [IW-1:0] it_r;
  logic outl_r, last_r;

  always_comb begin
    pc_v = pc_r;
    oc_v = oc_r;
    if (pc_r != CMAX) begin
      pc_v = pc_r + 1'b1;
      if (q_data[0]) oc_v = oc_r + 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hos_pkg::BK_IDLE: if (q_valid) st_nxt = q_data[1] ? hos_pkg::BK_DIV : hos_pkg::BK_OUT;
      hos_pkg::BK_DIV:  if (it_r == IW'(NW - 1)) st_nxt = hos_pkg::BK_OUT;
      hos_pkg::BK_OUT:  if (!out_stall) st_nxt = hos_pkg::BK_IDLE;
      default:          st_nxt = hos_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == hos_pkg::BK_IDLE) && q_valid;
    out_valid = (st_r == hos_pkg::BK_OUT);
  end

  assign rem_try = {rem_r[COUNT_BITS-1:0], num_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hos_pkg::BK_IDLE;
      oc_r <= '0;
      pc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        oc_r <= q_data[1] ? '0 : oc_v;
        pc_r <= q_data[1] ? '0 : pc_v;
      end
    end
    if (q_pop) begin
      outl_r <= q_data[0];
      last_r <= q_data[1];
      out_outlier_total <= hos_pkg::TOTAL_W'(oc_v);
      out_pair_total <= hos_pkg::TOTAL_W'(pc_v);
      num_r <= {oc_v, 16'd0};
      den_r <= pc_v;
      rem_r <= '0;
      it_r <= '0;
    end else if (st_r == hos_pkg::BK_DIV) begin
      it_r <= it_r + 1'b1;
      if (rem_try >= {1'b0, den_r}) begin
        rem_r <= rem_try - {1'b0, den_r};
        num_r <= {num_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_try;
        num_r <= {num_r[NW-2:0], 1'b0};
      end
    end
  end

  assign out_is_outlier = outl_r;
  assign out_done_res = last_r;
  assign out_outlier_ratio = last_r ? hos_pkg::RATIO_W'(num_r) : '0;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result beat dropped");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= pc_r) else $error("outlier count passed pair count");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == hos_pkg::BK_IDLE) else $error("pop outside idle");
endmodule
`default_nettype wire

### dv/hos_scoreboard.sv
// Checker for the homography outlier scorer: watches the config, input and result channels,
// predicts each result beat with its own projection and counters, and counts mismatches.
// Depends on hos_pkg.
`default_nettype none
module hos_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [11:0] in_ref_x,
  input  wire logic [11:0] in_ref_y,
  input  wire logic [11:0] in_src_x,
  input  wire logic [11:0] in_src_y,
  input  wire logic        in_last_pair,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_is_outlier,
  input  wire logic [15:0] out_outlier_total,
  input  wire logic [15:0] out_pair_total,
  input  wire logic [16:0] out_outlier_ratio,
  input  wire logic        out_done_res,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic        outlier;
    logic [15:0] outliers;
    logic [15:0] pairs;
    logic [16:0] ratio;
    logic        done;
  } score_t;

  score_t      score_q[$];
  logic [63:0] pair_a, pair_b, pair_c, pair_d;
  logic [31:0] h22;
  logic [19:0] thr;
  logic [15:0] outlier_cnt, pair_cnt;

  assign pending = score_q.size();

  function automatic logic is_outlier_pair(input logic [11:0] rx, ry, sx, sy);
    logic signed [63:0] x, y, zf, z;
    logic signed [127:0] dx, dy, lhs, rhs;
    x = $signed(pair_a[63:32]) * $signed({1'b0, sx}) + $signed(pair_a[31:0]) * $signed({1'b0, sy})
        + $signed(pair_b[63:32]);
    y = $signed(pair_b[31:0]) * $signed({1'b0, sx}) + $signed(pair_c[63:32]) * $signed({1'b0, sy})
        + $signed(pair_c[31:0]);
    zf = $signed(pair_d[63:32]) * $signed({1'b0, sx}) + $signed(pair_d[31:0]) * $signed({1'b0, sy})
         + $signed(h22);
    z = zf >>> 14;
    if (z == 0) return 1'b1;
    dx = x - $signed({1'b0, rx}) * z;
    dy = y - $signed({1'b0, ry}) * z;
    lhs = dx * dx + dy * dy;
    rhs = $signed({108'd0, thr}) * z * z;
    return lhs > rhs;
  endfunction

  always @(posedge clk) begin
    score_t exp_s, got_s;
    if (!rst_n) begin
      pair_a <= hos_pkg::PAIR_A_RST; pair_b <= hos_pkg::PAIR_B_RST;
      pair_c <= hos_pkg::PAIR_C_RST; pair_d <= hos_pkg::PAIR_D_RST;
      h22 <= hos_pkg::LAST_RST; thr <= hos_pkg::THR_RST;
      outlier_cnt = 0; pair_cnt = 0;
      score_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hos_pkg::REG_PAIR_A: pair_a <= cfg_data;
          hos_pkg::REG_PAIR_B: pair_b <= cfg_data;
          hos_pkg::REG_PAIR_C: pair_c <= cfg_data;
          hos_pkg::REG_PAIR_D: pair_d <= cfg_data;
          hos_pkg::REG_LAST: h22 <= cfg_data[31:0];
          hos_pkg::REG_THR: thr <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        exp_s.outlier = is_outlier_pair(in_ref_x, in_ref_y, in_src_x, in_src_y);
        if (pair_cnt != 16'hFFFF) begin
          pair_cnt = pair_cnt + 1;
          if (exp_s.outlier) outlier_cnt = outlier_cnt + 1;
        end
        exp_s.outliers = outlier_cnt;
        exp_s.pairs = pair_cnt;
        exp_s.done = in_last_pair;
        exp_s.ratio = 0;
        if (in_last_pair) begin
          exp_s.ratio = 17'(({16'd0, outlier_cnt} << 16) / pair_cnt);
          outlier_cnt = 0;
          pair_cnt = 0;
        end
        score_q = {score_q, exp_s};
      end
      if (out_valid && !out_stall) begin
        got_s = '{out_is_outlier, out_outlier_total, out_pair_total, out_outlier_ratio,
                  out_done_res};
        if (score_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result beat with nothing expected: %p", got_s);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = score_q.pop_front();
          if (got_s !== exp_s) begin
            if (fail_count < 10) $display("ERROR: expected %p got %p", exp_s, got_s);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### dv/tb_homography_outlier_scorer.sv
// Testbench top for the homography outlier scorer: clock, reset, config writes, pair
// stimulus with random gaps and stalls, and the verdict. Depends on hos_pkg, the block
// and hos_scoreboard.
`default_nettype none
module tb_homography_outlier_scorer;
  logic clk, rst_n;
  logic in_valid, in_stall, in_last_pair;
  logic [11:0] in_ref_x, in_ref_y, in_src_x, in_src_y;
  logic out_valid, out_stall, out_is_outlier, out_done_res;
  logic [15:0] out_outlier_total, out_pair_total;
  logic [16:0] out_outlier_ratio;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  int fail_count, pending, idle_cycles, hold_off;
  bit stim_done;

  homography_outlier_scorer dut (.*);
  hos_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver stall, including long hold-offs requested by the stimulus.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off = hold_off - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_pair(input logic [11:0] rx, ry, sx, sy, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_ref_x <= rx; in_ref_y <= ry; in_src_x <= sx; in_src_y <= sy;
    in_last_pair <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int n, input bit near_identity);
    logic [11:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = 12'($urandom);
      sy = 12'($urandom);
      if (near_identity && $urandom_range(0, 3) != 0)
        send_pair(12'(sx + $urandom_range(0, 6) - 3), 12'(sy + $urandom_range(0, 6) - 3),
                  sx, sy, $urandom_range(0, 15) == 0);
      else
        send_pair(12'($urandom), 12'($urandom), sx, sy, $urandom_range(0, 15) == 0);
    end
    send_pair(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 1'b1);
    in_valid <= 0;
  endtask

  task automatic random_config();
    write_reg(hos_pkg::REG_PAIR_A, {$urandom, $urandom});
    write_reg(hos_pkg::REG_PAIR_B, {$urandom, $urandom});
    write_reg(hos_pkg::REG_PAIR_C, {$urandom, $urandom});
    write_reg(hos_pkg::REG_PAIR_D, {$urandom, $urandom});
    write_reg(hos_pkg::REG_LAST, {32'd0, $urandom});
    write_reg(hos_pkg::REG_THR, 64'($urandom_range(0, 20'hFFFFF)));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_last_pair = 0;
    in_ref_x = 0; in_ref_y = 0; in_src_x = 0; in_src_y = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    hold_off = 0; stim_done = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Identity homography: exact, near and far pairs, field extremes.
    send_pair(0, 0, 0, 0, 0);
    send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0);
    send_pair(13, 10, 10, 10, 0);
    send_pair(12, 10, 10, 10, 0);
    send_pair(0, 12'hFFF, 12'hFFF, 0, 0);
    send_pair(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1);
    send_pair(7, 7, 7, 7, 1);
    in_valid <= 0;
    drain();

    // Zero perspective row gives zero Z; threshold and coefficient extremes.
    write_reg(hos_pkg::REG_LAST, 64'd0);
    send_pair(1, 2, 3, 4, 0);
    send_pair(0, 0, 0, 0, 1);
    in_valid <= 0;
    drain();
    write_reg(hos_pkg::REG_PAIR_A, 64'h8000_0000_7FFF_FFFF);
    write_reg(hos_pkg::REG_PAIR_B, 64'h7FFF_FFFF_8000_0000);
    write_reg(hos_pkg::REG_PAIR_C, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(hos_pkg::REG_PAIR_D, 64'h8000_0000_7FFF_FFFF);
    write_reg(hos_pkg::REG_LAST, 64'hFFFF_FFFF);
    write_reg(hos_pkg::REG_THR, 64'hFFFFF);
    send_pair(12'hFFF, 0, 12'hFFF, 12'hFFF, 0);
    send_pair(0, 12'hFFF, 0, 0, 0);
    send_pair(12'h800, 12'h800, 12'h001, 12'h800, 1);
    in_valid <= 0;
    drain();
    write_reg(hos_pkg::REG_THR, 64'd0);
    write_reg(hos_pkg::REG_PAIR_A, hos_pkg::PAIR_A_RST);
    write_reg(hos_pkg::REG_PAIR_B, 64'h0);
    write_reg(hos_pkg::REG_PAIR_C, hos_pkg::PAIR_C_RST);
    write_reg(hos_pkg::REG_PAIR_D, 64'h0);
    write_reg(hos_pkg::REG_LAST, 64'(hos_pkg::LAST_RST));
    send_pair(5, 5, 5, 5, 0);
    send_pair(6, 5, 5, 5, 1);
    in_valid <= 0;
    drain();

    // Near-identity sets with a long receiver hold-off to fill the block.
    write_reg(hos_pkg::REG_THR, 64'd9);
    hold_off = 200;
    send_random(200, 1);
    drain();

    random_config();
    send_random(100, 0);
    drain();

    write_reg(hos_pkg::REG_PAIR_A, hos_pkg::PAIR_A_RST);
    write_reg(hos_pkg::REG_PAIR_B, 64'h0);
    write_reg(hos_pkg::REG_PAIR_C, hos_pkg::PAIR_C_RST);
    write_reg(hos_pkg::REG_PAIR_D, 64'h0);
    write_reg(hos_pkg::REG_LAST, 64'h0000_4000);
    write_reg(hos_pkg::REG_THR, 64'd2);
    send_random(200, 1);
    drain();

    random_config();
    send_random(120, 0);
    stim_done = 1;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles > 5000) begin
        $display("FAIL homography_outlier_scorer");
        $finish;
      end
      if (stim_done && pending == 0) begin
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
          $display("PASS homography_outlier_scorer");
        else
          $display("FAIL homography_outlier_scorer");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
